// File: rtl/ufd_pkg.sv
`timescale 1ns / 1ps

package ufd_pkg;

   localparam logic [1:0] KIND_NAME     = 2'd0;
   localparam logic [1:0] KIND_VALUE    = 2'd1;
   localparam logic [1:0] KIND_PAIR_END = 2'd2;

   localparam logic [1:0] ESC_IDLE   = 2'd0;
   localparam logic [1:0] ESC_FIRST  = 2'd1;
   localparam logic [1:0] ESC_SECOND = 2'd2;

   localparam logic [7:0] CHAR_EQUAL   = 8'h3D;
   localparam logic [7:0] CHAR_AMP     = 8'h26;
   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F = 8'h66;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;
   localparam logic [7:0] HEX_TEN      = 8'd10;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] out_byte;
      logic       last_of_run;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } decode_type;

   // bit 4 is the digit flag, bits 3:0 the digit value (zero when not hex)
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] r;
      r = '0;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         r = {1'b1, 4'(c - CHAR_ZERO)};
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
         r = {1'b1, 4'(c - CHAR_LOWER_A + HEX_TEN)};
      end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
         r = {1'b1, 4'(c - CHAR_UPPER_A + HEX_TEN)};
      end
      return r;
   endfunction

endpackage

// File: rtl/ufd_if.sv
`timescale 1ns / 1ps

interface ufd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_string;

   modport source (output valid, output in_byte, output end_of_string, input ready);
   modport sink (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface ufd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] out_byte;
   logic       last_of_run;

   modport source (output valid, output kind, output out_byte, output last_of_run,
                   input ready);
   modport sink (input valid, input kind, input out_byte, input last_of_run,
                 output ready);
endinterface

// File: rtl/ufd_decode.sv
`timescale 1ns / 1ps

module ufd_decode (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        in_byte,
   input  logic              end_of_string,
   output ufd_pkg::decode_type decode
);

   logic [1:0] phase_ff, phase_in;
   logic [3:0] high_ff, high_in;
   logic       high_valid_ff, high_valid_in;
   logic       in_value_ff, in_value_in;
   logic       nonempty_ff, nonempty_in;

   logic [4:0] hex_b;
   logic       data_en;
   logic [7:0] data_byte;
   logic       amp_end;
   logic       tail_end;
   logic       first_en;
   ufd_pkg::result_type first_r;
   ufd_pkg::result_type tail_r;

   assign hex_b = ufd_pkg::hex_value(in_byte);

   always_comb begin
      data_en       = 1'b0;
      data_byte     = '0;
      amp_end       = 1'b0;
      phase_in      = phase_ff;
      high_in       = high_ff;
      high_valid_in = high_valid_ff;
      in_value_in   = in_value_ff;
      nonempty_in   = nonempty_ff;
      case (phase_ff)
         ufd_pkg::ESC_FIRST: begin
            high_valid_in = hex_b[4];
            high_in       = hex_b[3:0];
            phase_in      = ufd_pkg::ESC_SECOND;
            if (end_of_string) begin
               data_en   = 1'b1;
               data_byte = {4'b0, hex_b[3:0]};
            end
         end
         ufd_pkg::ESC_SECOND: begin
            data_en  = 1'b1;
            phase_in = ufd_pkg::ESC_IDLE;
            if (high_valid_ff) begin
               data_byte = hex_b[4] ? {high_ff, hex_b[3:0]} : {4'b0, high_ff};
            end
         end
         default: begin
            phase_in = ufd_pkg::ESC_IDLE;
            if (in_byte == ufd_pkg::CHAR_EQUAL) begin
               in_value_in = 1'b1;
            end else if (in_byte == ufd_pkg::CHAR_AMP) begin
               amp_end     = 1'b1;
               in_value_in = 1'b0;
               nonempty_in = 1'b0;
            end else if (in_byte == ufd_pkg::CHAR_PERCENT) begin
               phase_in = ufd_pkg::ESC_FIRST;
               data_en  = end_of_string;
            end else if (in_byte == ufd_pkg::CHAR_PLUS) begin
               data_en   = 1'b1;
               data_byte = ufd_pkg::CHAR_SPACE;
            end else begin
               data_en   = 1'b1;
               data_byte = in_byte;
            end
         end
      endcase

      if (data_en && !in_value_ff) begin
         nonempty_in = 1'b1;
      end

      tail_end = end_of_string && nonempty_in;
      first_en = data_en || amp_end;

      first_r.kind        = amp_end ? ufd_pkg::KIND_PAIR_END :
                            (in_value_ff ? ufd_pkg::KIND_VALUE : ufd_pkg::KIND_NAME);
      first_r.out_byte    = amp_end ? 8'd0 : data_byte;
      first_r.last_of_run = !tail_end;

      tail_r.kind        = ufd_pkg::KIND_PAIR_END;
      tail_r.out_byte    = '0;
      tail_r.last_of_run = 1'b1;

      decode.second = tail_r;
      case ({first_en, tail_end})
         2'b11: begin
            decode.count = 2'd2;
            decode.first = first_r;
         end
         2'b10: begin
            decode.count = 2'd1;
            decode.first = first_r;
         end
         2'b01: begin
            decode.count = 2'd1;
            decode.first = tail_r;
         end
         default: begin
            decode.count = 2'd0;
            decode.first = first_r;
         end
      endcase

      // end of string returns every field to its reset value
      if (end_of_string) begin
         phase_in      = ufd_pkg::ESC_IDLE;
         high_in       = '0;
         high_valid_in = 1'b0;
         in_value_in   = 1'b0;
         nonempty_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= ufd_pkg::ESC_IDLE;
         high_ff       <= '0;
         high_valid_ff <= 1'b0;
         in_value_ff   <= 1'b0;
         nonempty_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         high_ff       <= high_in;
         high_valid_ff <= high_valid_in;
         in_value_ff   <= in_value_in;
         nonempty_ff   <= nonempty_in;
      end
   end

endmodule

// File: rtl/ufd_result_queue.sv
`timescale 1ns / 1ps

module ufd_result_queue #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ufd_pkg::decode_type decode,
   output logic                can_accept,
   output logic                out_valid,
   input  logic                out_ready,
   output ufd_pkg::result_type out_result
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   ufd_pkg::result_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [1:0]       push_n;
   logic             pop;
   logic [PTR_W-1:0] wr_next;

   assign push_n     = push ? decode.count : 2'd0;
   assign pop        = out_valid && out_ready;
   assign out_valid  = count_ff != '0;
   assign out_result = entry_ff[rd_ptr_ff];
   assign can_accept = count_ff <= CNT_W'(DEPTH - 2);
   assign wr_next    = wr_ptr_ff + PTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push_n);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + CNT_W'(push_n) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         if (push_n != 2'd0 && PTR_W'(i) == wr_ptr_ff) begin
            entry_ff[i] <= decode.first;
         end
         if (push_n == 2'd2 && PTR_W'(i) == wr_next) begin
            entry_ff[i] <= decode.second;
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("result queue overflow");

   assert property (@(posedge clock) disable iff (reset)
      (pop && push_n == 2'd0) |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("result queue count lost a pop");

   assert property (@(posedge clock) disable iff (reset)
      (push_n == 2'd2) |-> (decode.second.last_of_run && !decode.first.last_of_run))
      else $error("run end misplaced in a two-result request");

   assert property (@(posedge clock) disable iff (reset)
      (push_n == 2'd1) |-> decode.first.last_of_run)
      else $error("single result without run end");

endmodule

// File: rtl/url_form_decoder_core.sv
`timescale 1ns / 1ps

// Streaming form-urlencoded decoder. One raw byte is taken per clock on req_bus while ready
// is high; decoded name bytes, value bytes and pair-end markers are written into the
// result queue as the byte is taken and leave its head on rsp_bus one per clock while
// rsp_bus.ready is high. A request yields zero, one or two results; with rsp_bus ready, a
// steady stream of requests that each give at most one result runs at one byte per clock.
// The result queue of QUEUE_DEPTH entries takes a new request only while two entries are
// free, so when requests give two results (a final byte that ends a non-empty pair) the
// input slows to match the output. QUEUE_DEPTH must be a power of two, at least 4.

module url_form_decoder_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic     clock,
   input  logic     reset,
   ufd_req_if.sink  req_bus,
   ufd_rsp_if.source rsp_bus
);

   ufd_pkg::decode_type decode;
   ufd_pkg::result_type head;
   logic                accept;
   logic                can_accept;

   assign req_bus.ready = can_accept;
   assign accept        = req_bus.valid && can_accept;

   ufd_decode u_decode (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .in_byte       (req_bus.in_byte),
      .end_of_string (req_bus.end_of_string),
      .decode        (decode)
   );

   ufd_result_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .decode     (decode),
      .can_accept (can_accept),
      .out_valid  (rsp_bus.valid),
      .out_ready  (rsp_bus.ready),
      .out_result (head)
   );

   assign rsp_bus.kind        = head.kind;
   assign rsp_bus.out_byte    = head.out_byte;
   assign rsp_bus.last_of_run = head.last_of_run;

endmodule
